@@ src/elg_pkg.sv @@
// Package: shared types, state and register codes for the ElGamal engine.
`timescale 1ns / 1ps
package elg_pkg;

  typedef enum logic [2:0] {
    REG_MODULUS    = 3'd0,
    REG_GENERATOR  = 3'd1,
    REG_PRIV_KEY   = 3'd2,
    REG_SESS_KEY   = 3'd3,
    REG_RECV_SESS  = 3'd4
  } reg_idx_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_D,     // start reduce of data word
    OP_LOAD_G,     // start reduce of generator into base
    OP_LOAD_R,     // start reduce of received session into base
    OP_LOAD_CR,    // start reduce of private key mod p-1
    OP_EXP_C,      // exponent := c
    OP_EXP_K,      // exponent := k
    OP_EXP_INV,    // exponent := (p-1) - (c mod (p-1))
    OP_BASE_ACC,   // base := acc
    OP_ACC_ONE,    // acc := 1 mod p
    OP_MUL_ACC,    // start acc*base mod p
    OP_MUL_SQR,    // start base*base mod p
    OP_MUL_D,      // start acc*d mod p, result to value
    OP_SAVE_PUB    // pub := acc
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;     // reduction unit running
    logic exp_zero; // exponent register is zero
    logic exp_lsb;  // exponent bit 0
    logic mod_ok;   // modulus at least two
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RED_D, ST_WAIT_D,
    ST_LD_BASE, ST_WAIT_BASE, ST_LD_EXP, ST_WAIT_EXP, ST_EXP_INIT,
    ST_EXP_TEST, ST_EXP_MUL, ST_EXP_MUL_W, ST_EXP_SQR, ST_EXP_SQR_W,
    ST_EXP_DONE, ST_FIN_MUL, ST_FIN_W, ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {PH_PUBKEY, PH_MASK, PH_PUB, PH_DEC} phase_t;

endpackage

@@ src/elg_if.sv @@
// Interfaces: valid/ready channels for input and result words.
`timescale 1ns / 1ps
interface elg_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] data_in;
  modport source (output valid, func, data_in, input ready);
  modport sink (input valid, func, data_in, output ready);
endinterface

interface elg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [31:0] session_public;
  modport source (output valid, value, session_public, input ready);
  modport sink (input valid, value, session_public, output ready);
endinterface

@@ src/elgamal_cipher.sv @@
// Top level: ElGamal engine with configuration registers and word channels.
//   channel | dir | handshake       | payload
//   in      | in  | in_valid/ready  | func, data_in
//   out     | out | out_valid/ready | value, session_public
//   cfg     | in  | APB             | registers 0..4 at 4*i
// An item runs up to three square-and-multiply passes; each exponent bit runs one
// or two modular products through the bit-serial reducer, which shifts one bit
// per cycle. One item at a time; input stalls until the result is taken, and
// the result holds until taken. rst_n is synchronous and restores register
// defaults.
`timescale 1ns / 1ps
module elgamal_cipher #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  elg_in_if.sink      in_ch,
  elg_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import elg_pkg::*;

  localparam int W = WORD_BITS;

  logic [W-1:0] mod_r, gen_r, priv_r, sess_r, recv_r;
  logic [W-1:0] data_r, val_w, pub_w;
  logic         func_r, load_in;
  dp_cmd_t      cmd;
  dp_stat_t     stat;
  reg_idx_t     widx;

  assign cfg_pready = 1'b1;
  assign widx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(3); gen_r <= W'(2); priv_r <= W'(1);
      sess_r <= W'(1); recv_r <= W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_MODULUS:   mod_r  <= cfg_pwdata[W-1:0];
        REG_GENERATOR: gen_r  <= cfg_pwdata[W-1:0];
        REG_PRIV_KEY:  priv_r <= cfg_pwdata[W-1:0];
        REG_SESS_KEY:  sess_r <= cfg_pwdata[W-1:0];
        REG_RECV_SESS: recv_r <= cfg_pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODULUS:   cfg_prdata = 32'(mod_r);
      REG_GENERATOR: cfg_prdata = 32'(gen_r);
      REG_PRIV_KEY:  cfg_prdata = 32'(priv_r);
      REG_SESS_KEY:  cfg_prdata = 32'(sess_r);
      REG_RECV_SESS: cfg_prdata = 32'(recv_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      func_r <= in_ch.func;
      data_r <= in_ch.data_in[W-1:0];
    end
  end

  elg_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .func(func_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .load_in, .cmd, .stat
  );

  elg_datapath #(.WORD_BITS(W)) u_dp (
    .clk, .rst_n, .cmd, .stat, .func(func_r), .data_in(data_r),
    .modulus(mod_r), .generator(gen_r), .private_key(priv_r),
    .session_key(sess_r), .received_session(recv_r),
    .value(val_w), .session_public(pub_w)
  );

  assign out_ch.value          = 32'(val_w);
  assign out_ch.session_public = 32'(pub_w);
endmodule

@@ src/elg_datapath.sv @@
// Datapath: operand registers, multiplier and bit-serial modular reducer.
`timescale 1ns / 1ps
module elg_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  elg_pkg::dp_cmd_t      cmd,
  output elg_pkg::dp_stat_t     stat,
  input  logic                  func,
  input  logic [WORD_BITS-1:0]  data_in,
  input  logic [WORD_BITS-1:0]  modulus,
  input  logic [WORD_BITS-1:0]  generator,
  input  logic [WORD_BITS-1:0]  private_key,
  input  logic [WORD_BITS-1:0]  session_key,
  input  logic [WORD_BITS-1:0]  received_session,
  output logic [WORD_BITS-1:0]  value,
  output logic [WORD_BITS-1:0]  session_public
);
  import elg_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * WORD_BITS;
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [2:0] {
    DST_D, DST_BASE, DST_ACC, DST_CR, DST_VAL
  } dst_t;

  logic [W-1:0]  d_r, base_r, acc_r, exp_r, cr_r, val_r, pub_r;
  logic [PW-1:0] num_r, num_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  dst_t          dst_r;
  logic [W-1:0]  pm1;

  assign pm1 = modulus - W'(1);

  // Shift-subtract: one numerator bit per cycle.
  always_comb begin
    logic [W:0] sh;
    sh      = {rem_r[W-1:0], num_r[PW-1]};
    num_nxt = {num_r[PW-2:0], 1'b0};
    if (sh >= {1'b0, div_r}) begin
      rem_nxt = sh - {1'b0, div_r};
    end else begin
      rem_nxt = sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD_D: begin
          num_r <= PW'(data_in); div_r <= modulus; rem_r <= '0;
          dst_r <= DST_D; busy_r <= 1'b1; cnt_r <= CW'(PW);
        end
        OP_LOAD_G: begin
          num_r <= PW'(generator); div_r <= modulus; rem_r <= '0;
          dst_r <= DST_BASE; busy_r <= 1'b1; cnt_r <= CW'(PW);
        end
        OP_LOAD_R: begin
          num_r <= PW'(received_session); div_r <= modulus; rem_r <= '0;
          dst_r <= DST_BASE; busy_r <= 1'b1; cnt_r <= CW'(PW);
        end
        OP_LOAD_CR: begin
          num_r <= PW'(private_key); div_r <= pm1; rem_r <= '0;
          dst_r <= DST_CR; busy_r <= 1'b1; cnt_r <= CW'(PW);
        end
        OP_MUL_ACC: begin
          num_r <= PW'(acc_r) * PW'(base_r); div_r <= modulus; rem_r <= '0;
          dst_r <= DST_ACC; busy_r <= 1'b1; cnt_r <= CW'(PW);
        end
        OP_MUL_SQR: begin
          num_r <= PW'(base_r) * PW'(base_r); div_r <= modulus; rem_r <= '0;
          dst_r <= DST_BASE; busy_r <= 1'b1; cnt_r <= CW'(PW);
          exp_r <= exp_r >> 1;
        end
        OP_MUL_D: begin
          num_r <= PW'(acc_r) * PW'(d_r); div_r <= modulus; rem_r <= '0;
          dst_r <= DST_VAL; busy_r <= 1'b1; cnt_r <= CW'(PW);
        end
        OP_EXP_C:    exp_r <= private_key;
        OP_EXP_K:    exp_r <= session_key;
        OP_EXP_INV:  exp_r <= pm1 - cr_r;
        OP_BASE_ACC: base_r <= acc_r;
        OP_ACC_ONE:  acc_r <= W'(1);
        OP_SAVE_PUB: pub_r <= acc_r;
        OP_NONE: begin
          if (busy_r) begin
            num_r <= num_nxt;
            rem_r <= rem_nxt;
            cnt_r <= cnt_r - CW'(1);
            if (cnt_r == CW'(1)) begin
              busy_r <= 1'b0;
              case (dst_r)
                DST_D:    d_r    <= rem_nxt[W-1:0];
                DST_BASE: base_r <= rem_nxt[W-1:0];
                DST_ACC:  acc_r  <= rem_nxt[W-1:0];
                DST_CR:   cr_r   <= rem_nxt[W-1:0];
                DST_VAL:  val_r  <= rem_nxt[W-1:0];
                default:  ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.busy     = busy_r;
  assign stat.exp_zero = (exp_r == '0);
  assign stat.exp_lsb  = exp_r[0];
  assign stat.mod_ok   = (modulus >= W'(2));

  always_comb begin
    value          = stat.mod_ok ? val_r : '0;
    session_public = (stat.mod_ok && !func) ? pub_r : '0;
  end
endmodule

@@ src/elg_ctrl.sv @@
// Controller: sequences reductions and square-and-multiply passes.
`timescale 1ns / 1ps
module elg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                load_in,
  output elg_pkg::dp_cmd_t    cmd,
  input  elg_pkg::dp_stat_t   stat
);
  import elg_pkg::*;

  ctl_state_t state_r, state_nxt;
  phase_t     ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_PUBKEY;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    load_in   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          load_in = 1'b1;
          state_nxt = ST_RED_D;
        end
      end
      ST_RED_D: begin
        if (!stat.mod_ok) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.op = OP_LOAD_D;
          state_nxt = ST_WAIT_D;
        end
      end
      ST_WAIT_D: begin
        if (!stat.busy) begin
          ph_nxt = func ? PH_DEC : PH_PUBKEY;
          state_nxt = func ? ST_LD_EXP : ST_LD_BASE;
        end
      end
      ST_LD_BASE: begin
        case (ph_r)
          PH_MASK: cmd.op = OP_BASE_ACC;
          PH_DEC:  cmd.op = OP_LOAD_R;
          default: cmd.op = OP_LOAD_G;
        endcase
        state_nxt = ST_WAIT_BASE;
      end
      ST_WAIT_BASE: begin
        if (!stat.busy) begin
          state_nxt = (ph_r == PH_DEC) ? ST_EXP_INIT : ST_LD_EXP;
          if (ph_r == PH_DEC) cmd.op = OP_EXP_INV;
        end
      end
      ST_LD_EXP: begin
        case (ph_r)
          PH_PUBKEY: begin cmd.op = OP_EXP_C; state_nxt = ST_EXP_INIT; end
          PH_DEC: begin cmd.op = OP_LOAD_CR; state_nxt = ST_WAIT_EXP; end
          default: begin cmd.op = OP_EXP_K; state_nxt = ST_EXP_INIT; end
        endcase
      end
      ST_WAIT_EXP: begin
        if (!stat.busy) state_nxt = ST_LD_BASE;
      end
      ST_EXP_INIT: begin
        cmd.op = OP_ACC_ONE;
        state_nxt = ST_EXP_TEST;
      end
      ST_EXP_TEST: begin
        if (stat.exp_zero) begin
          state_nxt = ST_EXP_DONE;
        end else if (stat.exp_lsb) begin
          state_nxt = ST_EXP_MUL;
        end else begin
          state_nxt = ST_EXP_SQR;
        end
      end
      ST_EXP_MUL: begin
        cmd.op = OP_MUL_ACC;
        state_nxt = ST_EXP_MUL_W;
      end
      ST_EXP_MUL_W: begin
        if (!stat.busy) state_nxt = ST_EXP_SQR;
      end
      ST_EXP_SQR: begin
        cmd.op = OP_MUL_SQR;
        state_nxt = ST_EXP_SQR_W;
      end
      ST_EXP_SQR_W: begin
        if (!stat.busy) state_nxt = ST_EXP_TEST;
      end
      ST_EXP_DONE: begin
        case (ph_r)
          PH_PUBKEY: begin ph_nxt = PH_MASK; state_nxt = ST_LD_BASE; end
          PH_MASK: begin
            ph_nxt = PH_PUB;
            state_nxt = ST_FIN_MUL;
          end
          PH_PUB: begin cmd.op = OP_SAVE_PUB; state_nxt = ST_OUT; end
          default: state_nxt = ST_FIN_MUL;
        endcase
      end
      ST_FIN_MUL: begin
        cmd.op = OP_MUL_D;
        state_nxt = ST_FIN_W;
      end
      ST_FIN_W: begin
        if (!stat.busy) begin
          state_nxt = (ph_r == PH_PUB) ? ST_LD_BASE : ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
